// ===== hdl/assert_macros.svh =====
// Assertion macros used by the order-statistic set module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent must be followed by the consequent in the same cycle.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Expression must never hold.
`define AST_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define AST_IMPLY(label, clk, rst_n, ante, cons)
`define AST_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== hdl/ossf_pkg.sv =====
// Types and constants for the order-statistic set.
package ossf_pkg;

	localparam int MODE_W = 2;
	localparam int OPND_W = 11;
	localparam int ANS_W  = 11;
	localparam int DATA_W = 16;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SELECT = 2'd2;
	localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd3;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_UPD   = 6'b000100,
		ST_PFX   = 6'b001000,
		ST_SEL   = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

endpackage

// ===== hdl/order_statistic_set_fenwick.sv =====
// Order-statistic set: presence bits and Fenwick counts in one memory, walked one level a cycle.
// Walk: insert/delete touch L tree levels upward (L at most log2(KEYS)+1); k-th smallest
// descends the tree by halving steps; count-below sums popcount(key) levels, none if key >= KEYS.
// One item at a time: no new item is accepted until the current item's walk through the single
// tree memory ends. A result waiting in the output register does not block accepting the next item.
// Reset: asynchronous, active low; then a clearing pass over all KEYS words with no item accepted.
`include "assert_macros.svh"

module order_statistic_set_fenwick
	import ossf_pkg::*;
#(
	parameter int KEYS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [10:0] operand, [15:11] zero
	input  logic [MODE_W-1:0] s_tuser,   // [1:0] mode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [10:0] answer, [15:11] zero
	output logic              m_tuser    // [0] invalid
);

	localparam int MAXSET = (KEYS < 2048) ? KEYS : 2048;
	localparam int CW     = $clog2(MAXSET + 1);
	localparam int AW     = $clog2(KEYS);
	localparam int PW     = $clog2(KEYS + 1);
	localparam int NW     = PW + 1;
	localparam int TOP    = 1 << (PW - 1);

	// word: [CW] key present, [CW-1:0] tree count
	logic [CW:0]   mem [KEYS];
	logic [CW:0]   rd_data_q;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [CW:0]   wr_data;

	state_t        state_q, state_d;
	logic [AW-1:0] clr_q, clr_d;
	logic [NW-1:0] pos_q, pos_d;
	logic [PW-1:0] step_q, step_d;
	logic [CW-1:0] acc_q, acc_d;
	logic          skip_q, skip_d;
	logic          first_q, first_d;
	logic          up_q, up_d;
	logic [CW-1:0] set_size_q, set_size_d;
	logic [ANS_W-1:0] ans_q, ans_d;
	logic          inv_q, inv_d;
	logic          m_tvalid_q;
	logic [ANS_W-1:0] m_ans_q;
	logic          m_inv_q;

	logic [OPND_W-1:0] in_opnd;
	logic          in_acc;
	logic          out_load;
	logic [CW-1:0] cnt, upd_cnt, pfx_sum, sel_rem;
	logic          pres, take;
	logic [NW-1:0] low, up_nxt, dn_nxt, sel_next, cand_take, cand_keep, sel_nxt;
	logic [PW-1:0] step_n;

	assign in_opnd   = s_tdata[OPND_W-1:0];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_RESP) && (!m_tvalid_q || m_tready);

	assign cnt       = rd_data_q[CW-1:0];
	assign pres      = rd_data_q[CW];
	assign upd_cnt   = up_q ? cnt + CW'(1) : cnt - CW'(1);
	assign pfx_sum   = acc_q + cnt;
	assign sel_rem   = acc_q - cnt;
	assign low       = pos_q & (~pos_q + NW'(1));
	assign up_nxt    = pos_q + low;
	assign dn_nxt    = pos_q - low;
	assign step_n    = step_q >> 1;
	assign sel_next  = pos_q + NW'(step_q);
	// both candidates for the next probe come from registers; rdata only picks one
	assign cand_take = sel_next + NW'(step_n);
	assign cand_keep = pos_q + NW'(step_n);
	assign take      = !skip_q && (cnt < acc_q);
	assign sel_nxt   = take ? cand_take : cand_keep;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		pos_d      = pos_q;
		step_d     = step_q;
		acc_d      = acc_q;
		skip_d     = skip_q;
		first_d    = first_q;
		up_d       = up_q;
		set_size_d = set_size_q;
		ans_d      = ans_q;
		inv_d      = inv_q;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				clr_d   = clr_q + AW'(1);
				if (clr_q == AW'(KEYS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) begin
					unique case (s_tuser)
						MODE_INSERT, MODE_DELETE: begin
							// keys outside the domain are dropped
							if (32'(in_opnd) < KEYS) begin
								rd_en   = 1'b1;
								rd_addr = AW'(in_opnd);
								pos_d   = NW'(in_opnd) + NW'(1);
								first_d = 1'b1;
								up_d    = (s_tuser == MODE_INSERT);
								state_d = ST_UPD;
							end
						end
						MODE_SELECT: begin
							if (in_opnd == '0 || 32'(in_opnd) > 32'(set_size_q)) begin
								ans_d   = '0;
								inv_d   = 1'b1;
								state_d = ST_RESP;
							end else begin
								pos_d   = '0;
								acc_d   = CW'(in_opnd);
								step_d  = PW'(TOP);
								skip_d  = 1'b0;
								rd_en   = 1'b1;
								rd_addr = AW'(TOP - 1);
								state_d = ST_SEL;
							end
						end
						MODE_COUNT: begin
							inv_d = 1'b0;
							if (32'(in_opnd) >= KEYS) begin
								ans_d   = ANS_W'(set_size_q);
								state_d = ST_RESP;
							end else if (in_opnd == '0) begin
								ans_d   = '0;
								state_d = ST_RESP;
							end else begin
								pos_d   = NW'(in_opnd);
								acc_d   = '0;
								rd_en   = 1'b1;
								rd_addr = AW'(in_opnd - OPND_W'(1));
								state_d = ST_PFX;
							end
						end
					endcase
				end
			end
			ST_UPD: begin
				if (first_q && pres == up_q) begin
					// already in the requested state: drop
					state_d = ST_IDLE;
				end else begin
					wr_en   = 1'b1;
					wr_addr = AW'(pos_q - NW'(1));
					wr_data = {(first_q ? up_q : pres), upd_cnt};
					if (first_q)
						set_size_d = up_q ? set_size_q + CW'(1) : set_size_q - CW'(1);
					first_d = 1'b0;
					if (up_nxt > NW'(KEYS)) begin
						state_d = ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = AW'(up_nxt - NW'(1));
						pos_d   = up_nxt;
					end
				end
			end
			ST_PFX: begin
				if (dn_nxt == '0) begin
					ans_d   = ANS_W'(pfx_sum);
					state_d = ST_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(dn_nxt - NW'(1));
					pos_d   = dn_nxt;
					acc_d   = pfx_sum;
				end
			end
			ST_SEL: begin
				if (take) begin
					pos_d = sel_next;
					acc_d = sel_rem;
				end
				step_d = step_n;
				if (step_n == '0) begin
					ans_d   = ANS_W'(take ? sel_next : pos_q);
					inv_d   = 1'b0;
					state_d = ST_RESP;
				end else if (sel_nxt > NW'(KEYS)) begin
					// probe past the tree end: never taken
					skip_d = 1'b1;
				end else begin
					skip_d  = 1'b0;
					rd_en   = 1'b1;
					rd_addr = AW'(sel_nxt - NW'(1));
				end
			end
			ST_RESP: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			set_size_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			set_size_q <= set_size_d;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		step_q  <= step_d;
		acc_q   <= acc_d;
		skip_q  <= skip_d;
		first_q <= first_d;
		up_q    <= up_d;
		ans_q   <= ans_d;
		inv_q   <= inv_d;
		if (out_load) begin
			m_ans_q <= ans_q;
			m_inv_q <= inv_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DATA_W'(m_ans_q);
	assign m_tuser  = m_inv_q;

	`AST_IMPLY(a_rw_apart, clk, arst_n, wr_en && rd_en, wr_addr != rd_addr)
	`AST_IMPLY(a_sel_rem_live, clk, arst_n, state_q == ST_SEL, acc_q != '0)
	`AST_IMPLY(a_out_from_resp, clk, arst_n, $rose(m_tvalid_q), $past(state_q == ST_RESP))
	`AST_NEVER(a_size_cap, clk, arst_n, set_size_q > CW'(MAXSET))
	`AST_IMPLY(a_clear_quiet, clk, arst_n, state_q == ST_CLEAR, !rd_en && !s_tready)

endmodule
